>>> hdl/gf3_pkg.sv
// gf3_pkg: widths, reset values, register codes and shared types of the
// 3x3 gaussian filter. no dependencies.
`default_nettype none

package gf3_pkg;

    localparam int PIX_W         = 8;
    localparam int WGT_W         = 16;
    localparam int SIDE_W        = 11;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    // sum of four pixels, product of weight and tap sum, sum of three products
    localparam int SUM4_W        = PIX_W + 2;
    localparam int PROD_W        = 27;
    localparam int ACC_W         = 29;

    localparam int DEF_MAX_SIDE  = 1024;
    localparam int DEF_FRAC_BITS = 14;
    localparam int MIN_SIDE      = 3;
    localparam int RST_SIDE      = 1024;

    localparam logic [WGT_W-1:0] RST_W_CENTER = 16'd2608;
    localparam logic [WGT_W-1:0] RST_W_EDGE   = 16'd1582;
    localparam logic [WGT_W-1:0] RST_W_CORNER = 16'd959;

    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE     = 8'd0,
        REG_W_CENTER = 8'd1,
        REG_W_EDGE   = 8'd2,
        REG_W_CORNER = 8'd3
    } t_cfg_reg;

    // per-pixel control travelling beside the line store read
    typedef struct packed {
        logic emit;
        logic last;
    } t_meta;

    typedef struct packed {
        logic signed [PIX_W-1:0]  c;
        logic signed [SUM4_W-1:0] e;
        logic signed [SUM4_W-1:0] k;
    } t_win_sum;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic                    last;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/gf3_if.sv
// gf3_if: valid/ready channel interfaces of the gaussian filter (pixel in,
// result out, register write). depends on gf3_pkg.
`default_nettype none

interface gf3_pix_if;
    logic                             valid;
    logic                             ready;
    logic signed [gf3_pkg::PIX_W-1:0] pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gf3_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [gf3_pkg::PIX_W-1:0] pixel_out;
    logic                             frame_last;
    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface gf3_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gf3_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [gf3_pkg::CFG_DATA_W-1:0]     wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

>>> hdl/gf3_window.sv
// gf3_window: line store memory (two rows packed per entry) with
// read-modify-write, 3x3 tap window and the tap group sums. depends on gf3_pkg.
`default_nettype none

module gf3_window #(
    parameter int MAX_SIDE = gf3_pkg::DEF_MAX_SIDE
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic signed [gf3_pkg::PIX_W-1:0] i_pixel,
    input  wire logic [$clog2(MAX_SIDE)-1:0]      i_addr,
    input  wire gf3_pkg::t_meta                   i_meta,
    output logic                                  o_valid,
    output gf3_pkg::t_win_sum                     o_sum,
    output gf3_pkg::t_meta                        o_meta
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int PW = gf3_pkg::PIX_W;
    localparam int SW4 = gf3_pkg::SUM4_W;

    // entry = {row two above, row one above}
    logic [2*PW-1:0] mem [MAX_SIDE];

    logic [2*PW-1:0]       r_rd;
    logic                  r_v1;
    logic signed [PW-1:0]  r_px;
    logic [AW-1:0]         r_addr;
    gf3_pkg::t_meta        r_meta;

    logic signed [PW-1:0]  r_win [3][3];
    logic signed [PW-1:0]  n_win [3][3];
    logic signed [PW-1:0]  up;
    logic signed [PW-1:0]  lo;

    logic                  r_v2;
    gf3_pkg::t_win_sum     r_sum;
    gf3_pkg::t_win_sum     n_sum;
    gf3_pkg::t_meta        r_meta2;

    assign up = $signed(r_rd[2*PW-1:PW]);
    assign lo = $signed(r_rd[PW-1:0]);

    // consecutive pixels always hit different columns (side >= 3), so the
    // write-back in the next cycle never meets a read of the same entry
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd <= mem[i_addr];
        end
        if (r_v1) begin
            mem[r_addr] <= {lo, r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_px   <= i_pixel;
            r_addr <= i_addr;
            r_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = up;
        n_win[1][2] = lo;
        n_win[2][2] = r_px;
    end

    always_comb begin
        n_sum.c = n_win[1][1];
        n_sum.e = SW4'(n_win[0][1]) + SW4'(n_win[1][0])
                + SW4'(n_win[1][2]) + SW4'(n_win[2][1]);
        n_sum.k = SW4'(n_win[0][0]) + SW4'(n_win[0][2])
                + SW4'(n_win[2][0]) + SW4'(n_win[2][2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (r_v1) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_sum   <= n_sum;
            r_meta2 <= r_meta;
        end
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;
    assign o_meta  = r_meta2;

endmodule

`default_nettype wire

>>> hdl/gf3_mac.sv
// gf3_mac: weight multiply, sum, truncation toward zero and saturation,
// three register stages. depends on gf3_pkg.
`default_nettype none

module gf3_mac #(
    parameter int WEIGHT_FRAC_BITS = gf3_pkg::DEF_FRAC_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_last,
    input  wire gf3_pkg::t_win_sum            i_sum,
    input  wire logic [gf3_pkg::WGT_W-1:0]    i_w_center,
    input  wire logic [gf3_pkg::WGT_W-1:0]    i_w_edge,
    input  wire logic [gf3_pkg::WGT_W-1:0]    i_w_corner,
    output logic                              o_valid,
    output gf3_pkg::t_result                  o_result
);

    localparam int PRW = gf3_pkg::PROD_W;
    localparam int ACW = gf3_pkg::ACC_W;
    localparam int PW  = gf3_pkg::PIX_W;
    localparam logic signed [ACW-1:0] BIAS  = ACW'((1 << WEIGHT_FRAC_BITS) - 1);
    localparam logic signed [ACW-1:0] Q_MAX = ACW'((2 ** (PW - 1)) - 1);
    localparam logic signed [ACW-1:0] Q_MIN = ACW'(-(2 ** (PW - 1)));

    logic signed [PRW-1:0] wc_x, we_x, wk_x, c_x, e_x, k_x;
    logic signed [PRW-1:0] r_pc, r_pe, r_pk;
    logic                  r_va, r_lasta;
    logic signed [ACW-1:0] r_acc;
    logic                  r_vb, r_lastb;
    logic signed [ACW-1:0] biased, q;
    gf3_pkg::t_result      r_res, n_res;
    logic                  r_vc;

    assign wc_x = PRW'($signed({1'b0, i_w_center}));
    assign we_x = PRW'($signed({1'b0, i_w_edge}));
    assign wk_x = PRW'($signed({1'b0, i_w_corner}));
    assign c_x  = PRW'(i_sum.c);
    assign e_x  = PRW'(i_sum.e);
    assign k_x  = PRW'(i_sum.k);

    always_ff @(posedge i_clk) begin
        r_pc    <= wc_x * c_x;
        r_pe    <= we_x * e_x;
        r_pk    <= wk_x * k_x;
        r_lasta <= i_last;
        r_acc   <= ACW'(r_pc) + ACW'(r_pe) + ACW'(r_pk);
        r_lastb <= r_lasta;
        r_res   <= n_res;
    end

    // negative sums get the bias so the arithmetic shift truncates toward zero
    always_comb begin
        biased = r_acc + (r_acc[ACW-1] ? BIAS : '0);
        q      = biased >>> WEIGHT_FRAC_BITS;
        n_res.last = r_lastb;
        if (q > Q_MAX) begin
            n_res.pixel = Q_MAX[PW-1:0];
        end else if (q < Q_MIN) begin
            n_res.pixel = Q_MIN[PW-1:0];
        end else begin
            n_res.pixel = q[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    assign o_valid  = r_vc;
    assign o_result = r_res;

endmodule

`default_nettype wire

>>> hdl/gf3_out_fifo.sv
// gf3_out_fifo: small result queue between the filter pipeline and the
// output channel. depends on gf3_pkg.
`default_nettype none

module gf3_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire gf3_pkg::t_result  i_data,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output gf3_pkg::t_result       o_data
);

    localparam int AW = gf3_pkg::FIFO_AW;
    localparam int CW = gf3_pkg::FIFO_CW;

    gf3_pkg::t_result r_mem [gf3_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

>>> hdl/gaussian_filter_3x3_core.sv
// gaussian_filter_3x3_core: top level of the 3x3 gaussian filter.
// depends on gf3_pkg, gf3_if, gf3_window, gf3_mac, gf3_out_fifo.
`default_nettype none

// One pixel request is taken every clock while the output side keeps up.
// Each pixel costs one read and one write-back of a single line store memory
// (both previous rows packed in one entry), which sets the rate at one pixel
// per cycle. A result reaches o_res after its pixel request has passed memory
// read, window and tap sums, multiply, sum, round and saturate and the result
// queue, and an eight-entry result queue lets the input keep flowing while
// results wait.
// Input ready drops only when eight results are queued or in flight. The line
// store needs no clearing after reset: the first two rows of a frame never
// reach a result. image_side is clamped to 3..MAX_SIDE and writing it
// restarts the frame; registers are to be written only when the block is idle.
module gaussian_filter_3x3_core #(
    parameter int MAX_SIDE         = gf3_pkg::DEF_MAX_SIDE,
    parameter int WEIGHT_FRAC_BITS = gf3_pkg::DEF_FRAC_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    gf3_pix_if.sink       i_pix,
    gf3_res_if.source     o_res,
    gf3_cfg_if.sink       i_cfg
);

    localparam int AW  = $clog2(MAX_SIDE);
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int CW  = (SW > gf3_pkg::SIDE_W) ? SW : gf3_pkg::SIDE_W;
    localparam int RS  = (gf3_pkg::RST_SIDE > MAX_SIDE) ? MAX_SIDE : gf3_pkg::RST_SIDE;
    localparam int FCW = gf3_pkg::FIFO_CW;

    logic [SW-1:0]             r_side, n_side;
    logic [CW-1:0]             side_x;
    logic [gf3_pkg::WGT_W-1:0] r_w_center, r_w_edge, r_w_corner;
    logic                      cfg_wr, side_wr;

    logic [AW-1:0]             r_col, r_row;
    logic [SW-1:0]             col_p1, row_p1;
    logic                      in_acc, out_acc;
    gf3_pkg::t_meta            meta;
    logic [FCW-1:0]            r_credit;

    logic                      win_valid;
    gf3_pkg::t_win_sum         win_sum;
    gf3_pkg::t_meta            win_meta;
    logic                      res_push;
    gf3_pkg::t_result          res_data, fifo_out;

    // register writes
    assign i_cfg.ready = i_rst_n;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign side_wr     = cfg_wr && (i_cfg.reg_index == gf3_pkg::REG_SIDE);

    always_comb begin
        side_x = CW'(i_cfg.wr_data[gf3_pkg::SIDE_W-1:0]);
        if (side_x < CW'(gf3_pkg::MIN_SIDE)) begin
            n_side = SW'(gf3_pkg::MIN_SIDE);
        end else if (side_x > CW'(MAX_SIDE)) begin
            n_side = SW'(MAX_SIDE);
        end else begin
            n_side = SW'(side_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= SW'(RS);
            r_w_center <= gf3_pkg::RST_W_CENTER;
            r_w_edge   <= gf3_pkg::RST_W_EDGE;
            r_w_corner <= gf3_pkg::RST_W_CORNER;
        end else if (cfg_wr) begin
            unique case (gf3_pkg::t_cfg_reg'(i_cfg.reg_index))
                gf3_pkg::REG_SIDE:     r_side     <= n_side;
                gf3_pkg::REG_W_CENTER: r_w_center <= i_cfg.wr_data;
                gf3_pkg::REG_W_EDGE:   r_w_edge   <= i_cfg.wr_data;
                gf3_pkg::REG_W_CORNER: r_w_corner <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // raster position
    assign in_acc    = i_pix.valid && i_pix.ready;
    assign out_acc   = o_res.valid && o_res.ready;
    assign col_p1    = SW'(r_col) + SW'(1);
    assign row_p1    = SW'(r_row) + SW'(1);
    assign meta.emit = (r_row >= AW'(2)) && (r_col >= AW'(2));
    assign meta.last = (row_p1 == r_side) && (col_p1 == r_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || side_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_p1 >= r_side) begin
                r_col <= '0;
                r_row <= (row_p1 >= r_side) ? '0 : AW'(row_p1);
            end else begin
                r_col <= AW'(col_p1);
            end
        end
    end

    // results queued or in flight; bounds the queue fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + FCW'(in_acc && meta.emit) - FCW'(out_acc);
        end
    end

    assign i_pix.ready = i_rst_n && (r_credit < FCW'(gf3_pkg::FIFO_DEPTH));

    gf3_window #(
        .MAX_SIDE (MAX_SIDE)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .i_pixel (i_pix.pixel_in),
        .i_addr  (r_col),
        .i_meta  (meta),
        .o_valid (win_valid),
        .o_sum   (win_sum),
        .o_meta  (win_meta)
    );

    gf3_mac #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (win_valid && win_meta.emit),
        .i_last     (win_meta.last),
        .i_sum      (win_sum),
        .i_w_center (r_w_center),
        .i_w_edge   (r_w_edge),
        .i_w_corner (r_w_corner),
        .o_valid    (res_push),
        .o_result   (res_data)
    );

    gf3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_data  (fifo_out)
    );

    assign o_res.pixel_out  = fifo_out.pixel;
    assign o_res.frame_last = fifo_out.last;

endmodule

`default_nettype wire

>>> hdl/gf3_checker.sv
// gf3_checker: port-level assertions for the gaussian filter top level,
// bound to gaussian_filter_3x3_core. depends on gf3_pkg.
`default_nettype none

module gf3_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [gf3_pkg::PIX_W-1:0] i_out_pixel,
    input wire logic                      i_out_last
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_pixel) && $stable(i_out_last))
        else $error("result changed while stalled");

    // reset empties the pipeline and the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // an empty queue only fills from a pixel request accepted through the full pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 6))
        else $error("result without matching pixel request");

    // no pixel request is taken during reset
    a_no_req_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |-> !i_in_ready)
        else $error("input ready during reset");

endmodule

bind gaussian_filter_3x3_core gf3_checker u_gf3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pixel (o_res.pixel_out),
    .i_out_last  (o_res.frame_last)
);

`default_nettype wire

>>> sim/gf3_blur_checker.sv
`timescale 1ns / 100ps
// gf3_blur_checker: watches the pixel, result and register channels of the gaussian
// filter, predicts every blurred pixel and compares it. depends on gf3_pkg.
module gf3_blur_checker
    import gf3_pkg::*;
#(
    parameter int MAX_SIDE  = DEF_MAX_SIDE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pix_valid,
    input  logic                    i_pix_ready,
    input  logic signed [PIX_W-1:0] i_pixel,
    input  logic                    i_res_valid,
    input  logic                    i_res_ready,
    input  logic signed [PIX_W-1:0] i_res_pixel,
    input  logic                    i_res_last,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_mismatches,
    output int                      o_outstanding
);

    logic [SIDE_W-1:0]       side_q;
    logic [WGT_W-1:0]        w_center;
    logic [WGT_W-1:0]        w_edge;
    logic [WGT_W-1:0]        w_corner;
    logic signed [PIX_W-1:0] row_above2 [MAX_SIDE];
    logic signed [PIX_W-1:0] row_above1 [MAX_SIDE];
    logic signed [PIX_W-1:0] taps [3][3];
    int unsigned             col_cnt;
    int unsigned             row_cnt;
    t_result                 blurred_q [$];
    t_result                 want;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic int unsigned clamped_side();
        if (side_q < MIN_SIDE) return MIN_SIDE;
        if (side_q > MAX_SIDE) return MAX_SIDE;
        return side_q;
    endfunction

    function automatic logic signed [PIX_W-1:0] blur_window();
        longint e_sum;
        longint k_sum;
        longint acc;
        longint q;
        e_sum = longint'(taps[0][1]) + longint'(taps[1][0])
              + longint'(taps[1][2]) + longint'(taps[2][1]);
        k_sum = longint'(taps[0][0]) + longint'(taps[0][2])
              + longint'(taps[2][0]) + longint'(taps[2][2]);
        acc = longint'(w_center) * longint'(taps[1][1])
            + longint'(w_edge) * e_sum + longint'(w_corner) * k_sum;
        // shift the magnitude so negative sums truncate toward zero
        if (acc >= 0) begin
            q = acc >>> FRAC_BITS;
        end else begin
            q = -((-acc) >>> FRAC_BITS);
        end
        if (q > 127) q = 127;
        if (q < -128) q = -128;
        return q[PIX_W-1:0];
    endfunction

    task automatic blur_step(input logic signed [PIX_W-1:0] px);
        int unsigned             side;
        int unsigned             col;
        logic signed [PIX_W-1:0] up;
        logic signed [PIX_W-1:0] lo;
        t_result                 item;
        side = clamped_side();
        col  = col_cnt;
        if (col >= MAX_SIDE) col = 0;
        up = row_above2[col];
        lo = row_above1[col];
        row_above2[col] = lo;
        row_above1[col] = px;
        for (int i = 0; i < 3; i++) begin
            taps[i][0] = taps[i][1];
            taps[i][1] = taps[i][2];
        end
        taps[0][2] = up;
        taps[1][2] = lo;
        taps[2][2] = px;
        if (row_cnt >= 2 && col >= 2) begin
            item.pixel = blur_window();
            item.last  = (row_cnt + 1 == side) && (col + 1 == side);
            blurred_q.push_back(item);
        end
        if (col + 1 >= side) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= side) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_q   = SIDE_W'(RST_SIDE);
            w_center = RST_W_CENTER;
            w_edge   = RST_W_EDGE;
            w_corner = RST_W_CORNER;
            for (int i = 0; i < MAX_SIDE; i++) begin
                row_above2[i] = '0;
                row_above1[i] = '0;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) taps[i][j] = '0;
            end
            col_cnt = 0;
            row_cnt = 0;
            blurred_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (blurred_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual pixel_out %0d frame_last %0b",
                             $time, i_res_pixel, i_res_last);
                    o_mismatches++;
                end else begin
                    want = blurred_q.pop_front();
                    if (i_res_pixel !== want.pixel) begin
                        $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                                 $time, want.pixel, i_res_pixel);
                        o_mismatches++;
                    end
                    if (i_res_last !== want.last) begin
                        $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                                 $time, want.last, i_res_last);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SIDE: begin
                        // a new side restarts the raster
                        side_q  = i_cfg_data[SIDE_W-1:0];
                        col_cnt = 0;
                        row_cnt = 0;
                    end
                    REG_W_CENTER: w_center = i_cfg_data;
                    REG_W_EDGE:   w_edge   = i_cfg_data;
                    REG_W_CORNER: w_corner = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) blur_step(i_pixel);
        end
        o_outstanding = blurred_q.size();
    end

endmodule

>>> sim/gaussian_filter_3x3_core_tb.sv
`timescale 1ns / 100ps
// gaussian_filter_3x3_core_tb: drives pixel requests and register writes into the
// filter under changing back-pressure. depends on gf3_pkg, gf3_if, gf3_blur_checker.
module gaussian_filter_3x3_core_tb;
    import gf3_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STAGE_ITEMS     = 180;
    localparam int MAX_BURST       = 60;
    localparam int WIDE_ITEMS      = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'd255;

    typedef enum logic [1:0] {
        IDLE_SLOW_SINK,
        IDLE_SLOW_SOURCE,
        IDLE_NONE
    } t_idle_mode;

    logic        i_clk;
    logic        i_rst_n;
    t_idle_mode  idle_mode   = IDLE_SLOW_SINK;
    logic        hold_off_go = 1'b0;
    int          mismatches;
    int          outstanding;
    int          cycle_count;
    int unsigned eff_side;

    gf3_pix_if pix ();
    gf3_res_if res ();
    gf3_cfg_if cfg ();

    gaussian_filter_3x3_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    gf3_blur_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (pix.valid),
        .i_pix_ready   (pix.ready),
        .i_pixel       (pix.pixel_in),
        .i_res_valid   (res.valid),
        .i_res_ready   (res.ready),
        .i_res_pixel   (res.pixel_out),
        .i_res_last    (res.frame_last),
        .i_cfg_valid   (cfg.valid),
        .i_cfg_ready   (cfg.ready),
        .i_cfg_index   (cfg.reg_index),
        .i_cfg_data    (cfg.wr_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SLOW_SINK:   return 31;
            IDLE_SLOW_SOURCE: return 88;
            default:          return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_mode)
            IDLE_SLOW_SINK:   return 88;
            IDLE_SLOW_SOURCE: return 31;
            default:          return 0;
        endcase
    endfunction

    // result side: random stalls, plus one long hold-off so the input backs up
    initial begin
        int   hold_left;
        logic hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_go && !hold_used) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
            end
        end
    end

    function automatic logic signed [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 8'sh80;
            1:       return 8'sh7F;
            2:       return 8'sh00;
            3:       return 8'shFF;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WGT_W'($urandom);
            default: return WGT_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_pixel(input logic signed [PIX_W-1:0] px);
        int pct;
        pct = send_idle_pct();
        while ($urandom_range(0, 99) < pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.pixel_in <= px;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    task automatic send_burst(input int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // registers are only touched once every result is out and the pipe is empty
    task automatic wait_drained();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wr_data   <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_side(input logic [CFG_DATA_W-1:0] data);
        write_reg(REG_SIDE, data);
        eff_side = data[SIDE_W-1:0];
        if (eff_side < MIN_SIDE) begin
            eff_side = MIN_SIDE;
        end else if (eff_side > DEF_MAX_SIDE) begin
            eff_side = DEF_MAX_SIDE;
        end
    endtask

    task automatic run_stage(input t_idle_mode mode, input int target);
        int sent;
        int n;
        int sel;
        idle_mode = mode;
        sent = 0;
        while (sent < target) begin
            wait_drained();
            if (sent == 0 || $urandom_range(0, 3) != 0) begin
                sel = $urandom_range(0, 15);
                if (sel == 0) begin
                    // undersized side, junk in the unused upper bits
                    set_side({5'($urandom), 11'($urandom_range(0, 2))});
                end else if (sel == 1) begin
                    set_side(CFG_DATA_W'($urandom_range(13, 20)));
                end else begin
                    set_side(CFG_DATA_W'($urandom_range(3, 10)));
                end
            end
            if ($urandom_range(0, 1)) write_reg(REG_W_CENTER, pick_weight());
            if ($urandom_range(0, 1)) write_reg(REG_W_EDGE, pick_weight());
            if ($urandom_range(0, 1)) write_reg(REG_W_CORNER, pick_weight());
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                          CFG_DATA_W'($urandom));
            end
            n = $urandom_range(1, 2 * eff_side * eff_side);
            if (n > MAX_BURST) n = MAX_BURST;
            send_burst(n);
            sent += n;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        pix.valid     <= 1'b0;
        pix.pixel_in  <= '0;
        cfg.valid     <= 1'b0;
        cfg.reg_index <= '0;
        cfg.wr_data   <= '0;
        eff_side = RST_SIDE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // side below the minimum acts as 3, full-scale weights saturate high
        set_side(CFG_DATA_W'(1));
        write_reg(REG_W_CENTER, '1);
        write_reg(REG_W_EDGE, '1);
        write_reg(REG_W_CORNER, '1);
        repeat (9) send_pixel(8'sh7F);
        wait_drained();

        // partial frame, then rewriting the side starts the raster over
        set_side(CFG_DATA_W'(4));
        write_reg(REG_W_CENTER, 16'd16383);
        write_reg(REG_W_EDGE, '0);
        write_reg(REG_W_CORNER, '0);
        send_burst(5);
        wait_drained();
        set_side(CFG_DATA_W'(4));
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, '0);
        // centre-only weight just under one: -1 and -128 truncate toward zero
        for (int i = 0; i < 16; i++) begin
            case (i)
                5:       send_pixel(8'shFF);
                6:       send_pixel(8'sh80);
                9:       send_pixel(8'sh7F);
                10:      send_pixel(8'sh00);
                default: send_pixel(rand_pixel());
            endcase
        end

        run_stage(IDLE_SLOW_SINK, STAGE_ITEMS);

        // oversized side clamps to the maximum; a short stretch of the first row
        idle_mode = IDLE_SLOW_SOURCE;
        wait_drained();
        set_side(CFG_DATA_W'(2047));
        write_reg(REG_W_CENTER, RST_W_CENTER);
        write_reg(REG_W_EDGE, RST_W_EDGE);
        write_reg(REG_W_CORNER, RST_W_CORNER);
        send_burst(WIDE_ITEMS);
        run_stage(IDLE_SLOW_SOURCE, STAGE_ITEMS);

        // full-rate input against a sink that holds off for a long stretch
        idle_mode = IDLE_NONE;
        wait_drained();
        set_side(CFG_DATA_W'(5));
        write_reg(REG_W_CENTER, pick_weight());
        hold_off_go = 1'b1;
        send_burst(200);
        run_stage(IDLE_NONE, STAGE_ITEMS);

        wait_drained();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
